// ===== design/fba_pkg.sv =====
// Shared types and constants for the fixed-size block allocator.
// Request/result payload structs, register map and operation codes.
// No dependencies.
package fba_pkg;

    localparam int IDX_W  = 10;
    localparam int SIZE_W = 21;
    localparam int MARK_W = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [0:0] REG_BLOCK_SIZE = 1'b0;
    localparam logic [0:0] REG_ROOT_BLOCK = 1'b1;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(64);

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_size;
        logic [IDX_W-1:0]  block_index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  result_index;
        logic              accepted;
        logic              root_cleared;
        logic [MARK_W-1:0] end_mark;
    } t_res;

    typedef struct packed {
        logic [SIZE_W-1:0] block_size;
        logic [IDX_W-1:0]  root_block;
        logic              root_set;
    } t_cfg;

endpackage

// ===== design/fba_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module fba_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fba_cfg.sv =====
// APB-style register block: block_size and root_block.
// Depends on fba_pkg.
module fba_cfg
    import fba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [SIZE_W-1:0] r_block_size;
    logic [IDX_W-1:0]  r_root_block;
    logic              wr_en;
    logic [0:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BLOCK_SIZE_RST;
            r_root_block <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BLOCK_SIZE: r_block_size <= pwdata[SIZE_W-1:0];
                REG_ROOT_BLOCK: r_root_block <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BLOCK_SIZE: prdata = PDATA_W'(r_block_size);
            REG_ROOT_BLOCK: prdata = PDATA_W'(r_root_block);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.block_size = r_block_size;
    assign o_cfg.root_block = r_root_block;
    // Writing the root register re-arms the root mark
    assign o_cfg.root_set   = wr_en && (reg_idx == REG_ROOT_BLOCK);

endmodule

// ===== design/fba_ctrl.sv =====
// Allocator sequencer: free-list head, end mark, root mark, result register.
// Drives the link memory (fba_ram). Depends on fba_pkg.
module fba_ctrl
    import fba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  t_req                          i_req,
    input  logic                          i_req_valid,
    output logic                          o_req_stall,
    output t_res                          o_res,
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_BLOCKS)-1:0] o_ram_addr,
    output logic [IDX_W-1:0]              o_ram_wdata,
    input  logic [IDX_W-1:0]              i_ram_rdata
);

    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int ECW = $clog2(MAX_BLOCKS + 1);
    localparam int CW  = (ECW > MARK_W) ? ECW : MARK_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_WALK_RD,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_head;
    logic [ECW-1:0]   r_end;
    logic             r_root_live;
    logic [IDX_W-1:0] r_res_idx;
    logic             r_res_acc;
    logic             r_res_rc;
    t_res             r_out;
    logic             r_out_valid;

    logic           req_take;
    logic           oversize;
    logic [CW-1:0]  idx_c;
    logic [CW-1:0]  end_c;
    logic           free_ok;
    logic           free_push;
    logic           root_hit;
    logic           walk_more;
    logic           emit_fire;

    assign req_take  = i_req_valid && (r_state == S_IDLE);
    assign oversize  = i_req.request_size > i_cfg.block_size;
    assign idx_c     = CW'(i_req.block_index);
    assign end_c     = CW'(r_end);
    assign free_ok   = (i_req.block_index != '0) && (idx_c < end_c);
    assign free_push = free_ok && ((idx_c + CW'(1)) < end_c);
    assign root_hit  = r_root_live && (i_cfg.root_block != '0)
                       && (i_cfg.root_block == i_req.block_index);
    assign walk_more = (r_head != '0) && ((CW'(r_head) + CW'(1)) == end_c);
    // Load the result register when it is empty or being drained
    assign emit_fire = (r_state == S_EMIT) && (!r_out_valid || !i_res_stall);

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_addr  = AW'(CW'(r_head));
        o_ram_wdata = r_head;
        if (req_take && !oversize && (i_req.func == FUNC_FREE) && free_push) begin
            o_ram_we   = 1'b1;
            o_ram_addr = AW'(idx_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_end       <= ECW'(1);
            r_root_live <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.root_set) begin
                r_root_live <= 1'b1;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_res_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_res_idx <= '0;
                        r_res_acc <= 1'b0;
                        r_res_rc  <= 1'b0;
                        r_state   <= S_EMIT;
                        if (oversize) begin
                            // nothing changes
                        end else if (i_req.func == FUNC_ALLOC) begin
                            if (r_head != '0) begin
                                // link of the head arrives next cycle
                                r_res_idx <= r_head;
                                r_res_acc <= 1'b1;
                                r_state   <= S_POP;
                            end else if (end_c < CW'(MAX_BLOCKS)) begin
                                r_res_idx <= IDX_W'(r_end);
                                r_res_acc <= 1'b1;
                                r_end     <= r_end + ECW'(1);
                            end
                        end else if (free_ok) begin
                            r_res_acc <= 1'b1;
                            if (root_hit) begin
                                r_root_live <= 1'b0;
                                r_res_rc    <= 1'b1;
                            end
                            if (free_push) begin
                                r_head <= i_req.block_index;
                            end else begin
                                // truncate, then walk heads just below the end
                                r_end   <= ECW'(idx_c);
                                r_state <= S_WALK;
                            end
                        end
                    end
                end
                S_POP: begin
                    r_head  <= i_ram_rdata;
                    r_state <= S_EMIT;
                end
                S_WALK: begin
                    if (walk_more) begin
                        r_end   <= ECW'(CW'(r_head));
                        r_state <= S_WALK_RD;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_WALK_RD: begin
                    r_head  <= i_ram_rdata;
                    r_state <= S_WALK;
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        r_out.result_index <= r_res_idx;
                        r_out.accepted     <= r_res_acc;
                        r_out.root_cleared <= r_res_rc;
                        r_out.end_mark     <= MARK_W'(end_c);
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

endmodule

// ===== design/fixed_block_free_list_allocator.sv =====
// Fixed-size block allocator with a linked free list: top level.
// Instantiates fba_cfg, fba_ctrl and fba_ram. Depends on fba_pkg.
//
// Usage:
//   Request channel i_req / i_req_valid / o_req_stall carries func (allocate
//   or free), request_size and block_index. Result channel o_res /
//   o_res_valid / i_res_stall returns result_index, accepted, root_cleared
//   and the end mark after the request.
//   A request is taken when valid is high and stall is low; one result per
//   request, in order.
//   Sequence: a taken request goes to S_EMIT, where the result register loads
//   once it is empty or being drained; no new request is taken before then.
//   An allocate that pops the free list first visits S_POP to read the link memory;
//   a free of the last block visits S_WALK, plus S_WALK_RD per list head pulled back.
//   A request is still taken while a finished result waits; its own result
//   then holds until the receiver drops stall.
//   Reset (synchronous, active low): empty free list, end mark 1, root mark
//   armed, block_size 64, root_block 0. The link memory is not cleared.
//   Configuration (block_size at 0x0, root_block at 0x4) must be written through the
//   APB port only while no request is in flight; the block itself does not enforce this.
module fixed_block_free_list_allocator
    import fba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  t_req               i_req,
    input  logic               i_req_valid,
    output logic               o_req_stall,
    output t_res               o_res,
    output logic               o_res_valid,
    input  logic               i_res_stall
);

    localparam int AW = $clog2(MAX_BLOCKS);

    t_cfg             cfg;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [IDX_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_rdata;

    fba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata)
    );

    fba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

endmodule
